// ===== hdl/ctd_pkg.sv =====
// Shared types, constants and helpers for the chunked transfer decoder.
package ctd_pkg;

    // Largest number of significant hex digits on one size line
    localparam int unsigned CTD_SIZE_DIGITS = 8;

    localparam logic [7:0] CTD_CH_LF   = 8'h0a;
    localparam logic [7:0] CTD_CH_CR   = 8'h0d;
    localparam logic [7:0] CTD_CH_0    = 8'h30;
    localparam logic [7:0] CTD_CH_9    = 8'h39;
    localparam logic [7:0] CTD_CH_UA   = 8'h41;
    localparam logic [7:0] CTD_CH_UF   = 8'h46;
    localparam logic [7:0] CTD_CH_LA   = 8'h61;
    localparam logic [7:0] CTD_CH_LF_F = 8'h66;

    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_DATA  = 3'd1,
        PH_SKIP  = 3'd2,
        PH_TRAIL = 3'd3,
        PH_DONE  = 3'd4,
        PH_ERR   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        TL_START = 2'd0,
        TL_CR    = 2'd1,
        TL_OTHER = 2'd2
    } t_trail;

    // Result of one processed beat
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        t_kind      kind;
    } t_result;

    // Hex digit value in bits [3:0]; bit 4 set means not a hex digit
    function automatic logic [4:0] ctd_hex_value(input logic [7:0] c);
        logic [4:0] v;
        begin
            v = 5'h10;
            if (c >= CTD_CH_0 && c <= CTD_CH_9) begin
                v = {1'b0, 4'(c - CTD_CH_0)};
            end else if (c >= CTD_CH_UA && c <= CTD_CH_UF) begin
                v = {1'b0, 4'(c - CTD_CH_UA + 8'd10)};
            end else if (c >= CTD_CH_LA && c <= CTD_CH_LF_F) begin
                v = {1'b0, 4'(c - CTD_CH_LA + 8'd10)};
            end
            return v;
        end
    endfunction

endpackage

// ===== hdl/ctd_parser.sv =====
// Chunk framing state machine: size line parse, data count, trailer lines.
module ctd_parser import ctd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    output t_result    o_result
);

    logic        r_enable;
    t_phase      r_phase,       n_phase;
    logic [31:0] r_size_accum,  n_size_accum;
    logic [4:0]  r_digit_count, n_digit_count;
    logic        r_closed,      n_closed;
    logic [31:0] r_bytes_left,  n_bytes_left;
    t_trail      r_trail,       n_trail;

    // Effective state after an optional message restart
    t_phase      c_phase;
    logic [31:0] c_size_accum;
    logic [4:0]  c_digit_count;
    logic        c_closed;
    logic [31:0] c_bytes_left;
    t_trail      c_trail;
    logic [4:0]  hv;
    logic [31:0] dec_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b1;
            r_phase       <= PH_SIZE;
            r_size_accum  <= '0;
            r_digit_count <= '0;
            r_closed      <= 1'b0;
            r_bytes_left  <= '0;
            r_trail       <= TL_START;
        end else begin
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (i_step && r_enable) begin
                r_phase       <= n_phase;
                r_size_accum  <= n_size_accum;
                r_digit_count <= n_digit_count;
                r_closed      <= n_closed;
                r_bytes_left  <= n_bytes_left;
                r_trail       <= n_trail;
            end
        end
    end

    always_comb begin
        if (i_start) begin
            c_phase       = PH_SIZE;
            c_size_accum  = '0;
            c_digit_count = '0;
            c_closed      = 1'b0;
            c_bytes_left  = '0;
            c_trail       = TL_START;
        end else begin
            c_phase       = r_phase;
            c_size_accum  = r_size_accum;
            c_digit_count = r_digit_count;
            c_closed      = r_closed;
            c_bytes_left  = r_bytes_left;
            c_trail       = r_trail;
        end

        hv       = ctd_hex_value(i_byte);
        dec_left = c_bytes_left - 32'd1;

        n_phase       = c_phase;
        n_size_accum  = c_size_accum;
        n_digit_count = c_digit_count;
        n_closed      = c_closed;
        n_bytes_left  = c_bytes_left;
        n_trail       = c_trail;
        o_result      = '{emit: 1'b0, data: 8'd0, kind: KIND_DATA};

        if (!r_enable) begin
            // pass-through: every beat is data, parser state held
            o_result = '{emit: 1'b1, data: i_byte, kind: KIND_DATA};
        end else begin
            case (c_phase)
                PH_SIZE: begin
                    if (i_byte == CTD_CH_LF) begin
                        if (c_size_accum == 32'd0) begin
                            n_phase = PH_TRAIL;
                            n_trail = TL_START;
                        end else begin
                            n_phase      = PH_DATA;
                            n_bytes_left = c_size_accum;
                        end
                        n_size_accum  = '0;
                        n_digit_count = '0;
                        n_closed      = 1'b0;
                    end else if (!c_closed) begin
                        if (hv[4]) begin
                            n_closed = 1'b1;
                        end else if (c_digit_count == 5'd0 && hv[3:0] == 4'd0) begin
                            // leading zero, skipped
                        end else if (c_digit_count >= 5'(CTD_SIZE_DIGITS)) begin
                            n_phase  = PH_ERR;
                            o_result = '{emit: 1'b1, data: 8'd0, kind: KIND_ERR};
                        end else begin
                            n_size_accum  = {c_size_accum[27:0], hv[3:0]};
                            n_digit_count = c_digit_count + 5'd1;
                        end
                    end
                end
                PH_DATA: begin
                    n_bytes_left = dec_left;
                    if (dec_left == 32'd0) begin
                        n_phase = PH_SKIP;
                    end
                    o_result = '{emit: 1'b1, data: i_byte, kind: KIND_DATA};
                end
                PH_SKIP: begin
                    if (i_byte == CTD_CH_LF) begin
                        n_phase       = PH_SIZE;
                        n_size_accum  = '0;
                        n_digit_count = '0;
                        n_closed      = 1'b0;
                    end
                end
                PH_TRAIL: begin
                    if (i_byte == CTD_CH_LF) begin
                        if (c_trail == TL_CR) begin
                            n_phase  = PH_DONE;
                            o_result = '{emit: 1'b1, data: 8'd0, kind: KIND_END};
                        end
                        n_trail = TL_START;
                    end else if (c_trail == TL_START && i_byte == CTD_CH_CR) begin
                        n_trail = TL_CR;
                    end else begin
                        n_trail = TL_OTHER;
                    end
                end
                default: begin
                    // done or error: drop until next message start
                end
            endcase
        end
    end

endmodule

// ===== hdl/chunked_transfer_decoder.sv =====
// An accepted beat is held in the input register until the result side is free or
// being taken; its result is then written to the result register, where o_valid shows it.
// Throughput: one beat per cycle; the input register and the result register
// both advance in the same cycle when the result side is free or being taken.
// Beats that frame the chunks produce no result. Reset (i_rst_n low, synchronous)
// empties both registers, enables decoding and restarts the size line parse.
module chunked_transfer_decoder import ctd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_msg_start,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_out_kind
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_kind      r_out_kind;
    logic       adv;
    t_result    res;

    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    ctd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (adv),
        .i_byte        (r_in_byte),
        .i_start       (r_in_start),
        .o_result      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= res.emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte  <= i_in_byte;
            r_in_start <= i_msg_start;
        end
        if (adv && res.emit) begin
            r_out_byte <= res.data;
            r_out_kind <= res.kind;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_kind = r_out_kind;

endmodule

// ===== tb/ctd_scoreboard_pkg.sv =====
// Scoreboard class for the chunked transfer decoder testbench.
`timescale 1ns / 1ps

package ctd_scoreboard_pkg;
    import ctd_pkg::*;

    typedef struct {
        logic [7:0] data;
        t_kind      kind;
    } t_dechunk_beat;

    class dechunk_scoreboard;
        bit            decode_on;
        t_phase        phase;
        logic [31:0]   size_accum;
        logic [4:0]    size_digits;
        bit            digits_done;
        logic [31:0]   chunk_left;
        t_trail        trail_state;
        t_dechunk_beat expected_beats[$];
        int            errors;
        int            n_data;
        int            n_end;
        int            n_err;

        function new();
            decode_on = 1'b1;
            errors    = 0;
            n_data    = 0;
            n_end     = 0;
            n_err     = 0;
            restart();
        endfunction

        function void restart();
            phase       = PH_SIZE;
            size_accum  = '0;
            size_digits = '0;
            digits_done = 1'b0;
            chunk_left  = '0;
            trail_state = TL_START;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= CTD_CH_0 && c <= CTD_CH_9) return int'(c - CTD_CH_0);
            if (c >= CTD_CH_UA && c <= CTD_CH_UF) return int'(c - CTD_CH_UA) + 10;
            if (c >= CTD_CH_LA && c <= CTD_CH_LF_F) return int'(c - CTD_CH_LA) + 10;
            return -1;
        endfunction

        function void push_expected(logic [7:0] b, t_kind k);
            expected_beats.push_back('{data: b, kind: k});
        endfunction

        function void clear_size_line();
            size_accum  = '0;
            size_digits = '0;
            digits_done = 1'b0;
        endfunction

        // Advance the decoder state by one accepted input beat
        function void predict_beat(logic [7:0] c, logic s);
            int hv;
            if (!decode_on) begin
                push_expected(c, KIND_DATA);
                return;
            end
            if (s) restart();
            case (phase)
                PH_SIZE: begin
                    if (c == CTD_CH_LF) begin
                        if (size_accum == 0) begin
                            phase       = PH_TRAIL;
                            trail_state = TL_START;
                        end else begin
                            phase      = PH_DATA;
                            chunk_left = size_accum;
                        end
                        clear_size_line();
                    end else if (!digits_done) begin
                        hv = hex_digit(c);
                        if (hv < 0) begin
                            digits_done = 1'b1;
                        end else if (!(size_digits == 0 && hv == 0)) begin
                            if (size_digits >= CTD_SIZE_DIGITS) begin
                                phase = PH_ERR;
                                push_expected(8'h00, KIND_ERR);
                            end else begin
                                size_accum  = {size_accum[27:0], 4'(hv)};
                                size_digits = size_digits + 5'd1;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    chunk_left = chunk_left - 32'd1;
                    if (chunk_left == 0) phase = PH_SKIP;
                    push_expected(c, KIND_DATA);
                end
                PH_SKIP: begin
                    if (c == CTD_CH_LF) begin
                        phase = PH_SIZE;
                        clear_size_line();
                    end
                end
                PH_TRAIL: begin
                    if (c == CTD_CH_LF) begin
                        // only a line that is exactly CR LF closes the message
                        if (trail_state == TL_CR) begin
                            phase = PH_DONE;
                            push_expected(8'h00, KIND_END);
                        end
                        trail_state = TL_START;
                    end else if (trail_state == TL_START && c == CTD_CH_CR) begin
                        trail_state = TL_CR;
                    end else begin
                        trail_state = TL_OTHER;
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string what);
            $display("MISMATCH: %s", what);
            errors++;
        endfunction

        function void check_beat(logic [7:0] b, logic [1:0] k);
            t_dechunk_beat want;
            if (expected_beats.size() == 0) begin
                report($sformatf("unexpected output beat byte=%02h kind=%0d", b, k));
                return;
            end
            want = expected_beats.pop_front();
            if (k !== want.kind)
                report($sformatf("kind %0d, want %s", k, want.kind.name()));
            if (b !== want.data)
                report($sformatf("byte %02h, want %02h (%s)",
                                 b, want.data, want.kind.name()));
            case (want.kind)
                KIND_DATA: n_data++;
                KIND_END:  n_end++;
                default:   n_err++;
            endcase
        endfunction
    endclass

endpackage

// ===== tb/chunked_transfer_decoder_test.sv =====
// Top of the chunked transfer decoder testbench: clock, reset, stimulus and output sink.
`timescale 1ns / 1ps

module chunked_transfer_decoder_test;
    import ctd_pkg::*;
    import ctd_scoreboard_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE       = 4;

    typedef enum int {
        MSG_GOOD,
        MSG_CUT,
        MSG_OVERFLOW,
        MSG_NOISE
    } t_msg_kind;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } t_raw_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic       i_cfg_wr_data;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       i_msg_start;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic [1:0] o_out_kind;

    dechunk_scoreboard sb = new();
    t_raw_beat         beat_q[$];
    t_raw_beat         held_q[$];
    bit                next_start;
    bit                calm_tx;
    bit                calm_rx;
    int                beats_sent;
    int                cfg_writes;
    int                cycles;

    chunked_transfer_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_msg_start   (i_msg_start),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_out_kind    (o_out_kind)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d beats still expected", cycles, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------- beat building ----------------

    task automatic push_beat(input logic [7:0] b);
        beat_q.push_back('{data: b, start: next_start});
        next_start = 1'b0;
    endtask

    task automatic push_text(input string t);
        for (int i = 0; i < t.len(); i++) push_beat(t[i]);
    endtask

    task automatic push_crlf();
        push_beat(CTD_CH_CR);
        push_beat(CTD_CH_LF);
    endtask

    // any byte but LF, so the line keeps going
    task automatic push_junk(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == CTD_CH_LF) b = "x";
            push_beat(b);
        end
    endtask

    task automatic push_digit(input int d, input bit upper);
        if (d < 10) push_beat(CTD_CH_0 + 8'(d));
        else if (upper) push_beat(CTD_CH_UA + 8'(d - 10));
        else push_beat(CTD_CH_LA + 8'(d - 10));
    endtask

    task automatic push_hex(input int unsigned v, input int zeros, input bit upper);
        int nib[$];
        for (int i = 0; i < zeros; i++) push_beat(CTD_CH_0);
        while (v != 0) begin
            nib.push_front(int'(v & 4'hf));
            v = v >> 4;
        end
        foreach (nib[i]) push_digit(nib[i], upper);
    endtask

    task automatic push_line_end();
        if ($urandom_range(0, 5) == 0) push_beat(CTD_CH_LF);
        else push_crlf();
    endtask

    task automatic build_good_message();
        int n_chunks;
        int size;
        n_chunks = $urandom_range(0, 3);
        for (int c = 0; c < n_chunks; c++) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300)
                                               : $urandom_range(1, 12);
            push_hex(size, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0,
                     1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
                push_text(";ext=");
                push_junk($urandom_range(0, 4));
            end
            push_line_end();
            for (int i = 0; i < size; i++) push_beat(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) == 0) begin
                push_junk($urandom_range(1, 3));
                push_beat(CTD_CH_LF);
            end else begin
                push_crlf();
            end
        end
        // last chunk: zero, empty line or a line with no hex digits
        case ($urandom_range(0, 5))
            0:       ;
            1:       push_text("zq;");
            default: push_hex(0, $urandom_range(1, 3), 1'b0);
        endcase
        if ($urandom_range(0, 3) == 0) push_text(";last");
        push_line_end();
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: push_beat(CTD_CH_LF);
                1: begin
                    push_beat(CTD_CH_CR);
                    push_junk($urandom_range(1, 2));
                    push_beat(CTD_CH_LF);
                end
                default: begin
                    push_text("X-Tr: ");
                    push_junk($urandom_range(0, 4));
                    push_crlf();
                end
            endcase
        end
        push_crlf();
        if ($urandom_range(0, 3) == 0) push_junk($urandom_range(1, 3));
    endtask

    task automatic build_message(input t_msg_kind kind);
        int cut;
        next_start = 1'b1;
        case (kind)
            MSG_GOOD: build_good_message();
            MSG_CUT: begin
                cut = beat_q.size();
                build_good_message();
                cut = cut + $urandom_range(1, beat_q.size() - cut);
                while (beat_q.size() > cut) void'(beat_q.pop_back());
            end
            MSG_OVERFLOW: begin
                push_hex(0, $urandom_range(0, 2), 1'b0);
                push_digit($urandom_range(1, 15), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(8, 10))
                    push_digit($urandom_range(0, 15), 1'($urandom_range(0, 1)));
                push_junk($urandom_range(0, 3));
                push_beat(CTD_CH_LF);
                push_junk($urandom_range(0, 4));
            end
            default: begin
                repeat ($urandom_range(5, 30)) begin
                    push_beat(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 9) == 0) next_start = 1'b1;
                end
            end
        endcase
    endtask

    function automatic t_msg_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return MSG_GOOD;
        if (r < 80) return MSG_CUT;
        if (r < 90) return MSG_OVERFLOW;
        return MSG_NOISE;
    endfunction

    // ---------------- driving ----------------

    task automatic send_beat(input logic [7:0] b, input logic s);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 99) == 0) calm_tx = !calm_tx;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_in_byte   <= b;
        i_msg_start <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.predict_beat(b, s);
        beats_sent++;
    endtask

    task automatic flush_beats(input int n);
        t_raw_beat rb;
        for (int i = 0; i < n && beat_q.size() > 0; i++) begin
            rb = beat_q.pop_front();
            send_beat(rb.data, rb.start);
        end
    endtask

    // hold the sender until every expected beat is out and the pipe is empty
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_decoding(input bit en);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= en;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.decode_on = en;
        cfg_writes++;
    endtask

    task automatic run_random(input int target);
        target = beats_sent + target;
        while (beats_sent < target) begin
            build_message(pick_kind());
            flush_beats(beat_q.size());
            if ($urandom_range(0, 39) == 0) drain();
        end
    endtask

    task automatic run_passthrough(input int n);
        repeat (n) begin
            next_start = 1'($urandom_range(0, 1));
            push_beat(8'($urandom_range(0, 255)));
        end
        push_beat(8'h00);
        push_beat(8'hff);
        flush_beats(beat_q.size());
    endtask

    // output side: random back-pressure, check every accepted beat
    initial begin
        int gap;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = calm_rx ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 99) == 0) calm_rx = !calm_rx;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            sb.check_beat(o_out_byte, o_out_kind);
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        i_valid       <= 1'b0;
        i_in_byte     <= 8'h00;
        i_msg_start   <= 1'b0;
        i_ready       <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: two-byte chunk with both byte extremes, then end
        next_start = 1'b1;
        push_text("2");
        push_crlf();
        push_beat(8'h00);
        push_beat(8'hff);
        push_crlf();
        push_text("0");
        push_crlf();
        push_crlf();
        // nine significant digits trip the size error; later bytes are dropped
        next_start = 1'b1;
        push_text("123456789x");
        // non-hex size line, a bare LF trailer that does not end, then CR LF
        next_start = 1'b1;
        push_text("z");
        push_beat(CTD_CH_LF);
        push_beat(CTD_CH_LF);
        push_crlf();
        flush_beats(beat_q.size());
        drain();

        run_random(500);

        // leave a message half done, pass through, then resume it
        build_message(MSG_GOOD);
        flush_beats(beat_q.size() / 2);
        held_q = beat_q;
        beat_q.delete();
        set_decoding(1'b0);
        run_passthrough(150);
        set_decoding(1'b1);
        beat_q = held_q;
        flush_beats(beat_q.size());

        run_random(430);
        set_decoding(1'b0);
        run_passthrough(50);
        set_decoding(1'b1);
        run_random(150);

        drain();
        $display("Sent %0d beats with %0d config writes", beats_sent, cfg_writes);
        $display("Checked %0d data, %0d end, %0d error beats; mismatches: %0d",
                 sb.n_data, sb.n_end, sb.n_err, sb.errors);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
